FILE: rtl/core/radio_channel_agility_manager_core_defines.svh
// Assertion macros shared by the channel agility manager RTL.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef RADIO_CHANNEL_AGILITY_MANAGER_CORE_DEFINES_SVH
`define RADIO_CHANNEL_AGILITY_MANAGER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RCAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RCAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RCAM_ASSERT(lbl, prop, msg)
`define RCAM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rcam_pkg.sv
// Types, constants and helper functions of the channel agility manager.
// Depends on nothing.
package rcam_pkg;

  localparam int SLOT_MAX     = 8;
  localparam int CHANNELS_DEF = 8;
  localparam int IDX_W        = 3;
  localparam int CNT_W        = 8;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic [CNT_W-1:0] MAX_TX_RST    = 8'd3;
  localparam logic [CNT_W-1:0] NUM_NODES_RST = 8'd16;

  localparam logic REG_MAX_TX    = 1'b0;
  localparam logic REG_NUM_NODES = 1'b1;

  typedef enum logic [1:0] {
    OP_ASSIGN      = 2'd0,
    OP_TX_USED     = 2'd1,
    OP_PEER_REPORT = 2'd2,
    OP_NOP         = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [IDX_W-1:0] channel;
    logic [CNT_W-1:0] peer_used_0;
    logic [CNT_W-1:0] peer_used_1;
    logic [CNT_W-1:0] peer_used_2;
    logic [CNT_W-1:0] peer_used_3;
    logic [CNT_W-1:0] peer_used_4;
    logic [CNT_W-1:0] peer_used_5;
    logic [CNT_W-1:0] peer_used_6;
    logic [CNT_W-1:0] peer_used_7;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]    picked_channel;
    logic                channel_full;
    logic                restored;
    logic [IDX_W-1:0]    restored_slot;
    logic [CNT_W-1:0]    restored_frequency;
    logic [SLOT_MAX-1:0] availability_now;
  } out_word_t;

  typedef struct packed {
    logic tx_inc;
    logic peer_sel;
  } lane_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic full_hit;
    logic renew_hit;
  } lane_stat_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

  function automatic pick_t lowest_set(input logic [SLOT_MAX-1:0] m);
    pick_t p;
    p = '0;
    for (int i = SLOT_MAX - 1; i >= 0; i--) begin
      if (m[i]) begin
        p.found = 1'b1;
        p.idx   = IDX_W'(i);
      end
    end
    return p;
  endfunction

endpackage

FILE: rtl/core/rcam_word_if.sv
// Valid/ready channel that carries one word of a given payload type.
// Depends on nothing; the payload type comes from the instance.
interface rcam_word_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/rcam_cfg.sv
// APB-style register file for the transmit limit and the node count.
// Depends on rcam_pkg.
module rcam_cfg
  import rcam_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  tx_limit,
  output logic [CNT_W-1:0]  num_nodes
);

  logic [CNT_W-1:0] max_tx_r;
  logic [CNT_W-1:0] nodes_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tx_r <= MAX_TX_RST;
      nodes_r  <= NUM_NODES_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_TX:    max_tx_r <= pwdata[CNT_W-1:0];
        REG_NUM_NODES: nodes_r  <= pwdata[CNT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_TX:    prdata = APB_DW'(max_tx_r);
      REG_NUM_NODES: prdata = APB_DW'(nodes_r);
      default:       prdata = '0;
    endcase
  end

  assign tx_limit  = max_tx_r;
  assign num_nodes = nodes_r;

endmodule

FILE: rtl/core/rcam_lane.sv
// One channel slot: transmit counter, fill count and their compare logic.
// Depends on rcam_pkg.
module rcam_lane
  import rcam_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] tx_limit,
  input  logic [CNT_W-1:0] num_nodes,
  input  logic [CNT_W-1:0] peer_used,
  input  lane_cmd_t        cmd,
  output lane_stat_t       stat
);

  logic [CNT_W-1:0] tx_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] tx_plus;
  logic [CNT_W-1:0] fill_max;

  assign tx_plus  = tx_r + 1'b1;
  assign fill_max = (fill_r < peer_used) ? peer_used : fill_r;

  assign stat.at_limit  = (tx_r == tx_limit);
  assign stat.full_hit  = (tx_plus >= tx_limit);
  assign stat.renew_hit = (fill_max == num_nodes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r   <= '0;
      fill_r <= '0;
    end else if (cmd.tx_inc) begin
      tx_r <= tx_plus;
      if (stat.full_hit) begin
        fill_r <= fill_r + 1'b1;
      end
    end else if (cmd.peer_sel) begin
      fill_r <= fill_max;
      if (stat.renew_hit) begin
        tx_r <= '0;
      end
    end
  end

endmodule

FILE: rtl/core/rcam_merge.sv
// Merging stage: slot searches, availability mask, frequency counter and lane commands.
// Depends on rcam_pkg and the assertion macro header.
`include "radio_channel_agility_manager_core_defines.svh"
module rcam_merge
  import rcam_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  opcode_t          opcode,
  input  logic [IDX_W-1:0] channel,
  input  lane_stat_t       stat [CHANNELS],
  output lane_cmd_t        cmd [CHANNELS],
  output out_word_t        result
);

  logic [CHANNELS-1:0] mask_r;
  logic [CHANNELS-1:0] mask_nxt;
  logic [CNT_W-1:0]    nfreq_r;
  logic [CNT_W-1:0]    nfreq_nxt;
  logic [SLOT_MAX-1:0] above;
  logic [SLOT_MAX-1:0] below;
  logic [SLOT_MAX-1:0] limit_vec;
  logic [CHANNELS-1:0] tx_vec;
  logic [CHANNELS-1:0] sel_vec;
  logic                renew;
  pick_t               pick_above;
  pick_t               pick_below;
  pick_t               pick_limit;

  always_comb begin
    above     = '0;
    below     = '0;
    limit_vec = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      above[i]     = mask_r[i] && (IDX_W'(i) > channel);
      below[i]     = mask_r[i] && (IDX_W'(i) < channel);
      limit_vec[i] = stat[i].at_limit;
    end
    pick_above = lowest_set(above);
    pick_below = lowest_set(below);
    pick_limit = lowest_set(limit_vec);
  end

  always_comb begin
    mask_nxt  = mask_r;
    nfreq_nxt = nfreq_r;
    tx_vec    = '0;
    sel_vec   = '0;
    renew     = 1'b0;
    result    = '0;
    unique case (opcode)
      OP_ASSIGN: begin
        if (pick_above.found) begin
          result.picked_channel = pick_above.idx;
        end else if (pick_below.found) begin
          result.picked_channel = pick_below.idx;
        end else begin
          result.picked_channel = channel;
        end
      end
      OP_TX_USED: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (channel == IDX_W'(i)) begin
            tx_vec[i] = 1'b1;
            if (stat[i].full_hit) begin
              result.channel_full = 1'b1;
              mask_nxt[i]         = 1'b0;
            end
          end
        end
      end
      OP_PEER_REPORT: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (pick_limit.found && pick_limit.idx == IDX_W'(i)) begin
            sel_vec[i] = 1'b1;
            if (stat[i].renew_hit) begin
              renew       = 1'b1;
              mask_nxt[i] = 1'b1;
            end
          end
        end
        if (renew) begin
          nfreq_nxt                 = nfreq_r + 1'b1;
          result.restored           = 1'b1;
          result.restored_slot      = pick_limit.idx;
          result.restored_frequency = nfreq_nxt;
        end
      end
      OP_NOP: ;
      default: ;
    endcase
    result.availability_now = SLOT_MAX'(mask_nxt);
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      cmd[i].tx_inc   = accept && tx_vec[i];
      cmd[i].peer_sel = accept && sel_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '1;
      nfreq_r <= CNT_W'(CHANNELS - 1);
    end else if (accept) begin
      mask_r  <= mask_nxt;
      nfreq_r <= nfreq_nxt;
    end
  end

  `RCAM_ASSERT(a_tx_onehot, $onehot0(tx_vec), "transmit-used addressed more than one slot")
  `RCAM_ASSERT(a_sel_onehot, $onehot0(sel_vec), "peer report selected more than one slot")
  `RCAM_ASSERT_NEXT(a_freq_step, accept && renew, nfreq_r == $past(nfreq_r) + 1'b1, "freq stuck")

endmodule

FILE: rtl/core/radio_channel_agility_manager_core.sv
// Top level of the channel agility manager: slot lanes, merging stage, registers.
// Depends on rcam_pkg, rcam_word_if, rcam_cfg, rcam_lane and rcam_merge.
//
//   channel   direction  word            handshake
//   in_word   sink       in_word_t       valid/ready
//   out_word  source     out_word_t      valid/ready
//   cfg       slave      32-bit register APB, pready tied high
//
// Each accepted word has its result in the output register from the next
// cycle, and a new word is taken in the same cycle that the result leaves.
// The lanes compare all slots at once and the merging stage encodes priority over them,
// so throughput is one word per cycle while the output is not stalled. Reset is synchronous;
// after it all slots are available. A stalled output holds the input off until it is taken.
module radio_channel_agility_manager_core
  import rcam_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rcam_word_if.sink         in_word,
  rcam_word_if.source       out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] max_tx_v;
  logic [CNT_W-1:0] num_nodes_v;
  logic [CNT_W-1:0] peer_v [SLOT_MAX];
  logic             accept;
  logic             out_valid_r;
  out_word_t        out_data_r;
  out_word_t        result;
  in_word_t         word;
  lane_stat_t       stat [CHANNELS];
  lane_cmd_t        cmd [CHANNELS];

  assign word           = in_word.data;
  assign in_word.ready  = !out_valid_r || out_word.ready;
  assign accept         = in_word.valid && in_word.ready;
  assign out_word.valid = out_valid_r;
  assign out_word.data  = out_data_r;

  assign peer_v[0] = word.peer_used_0;
  assign peer_v[1] = word.peer_used_1;
  assign peer_v[2] = word.peer_used_2;
  assign peer_v[3] = word.peer_used_3;
  assign peer_v[4] = word.peer_used_4;
  assign peer_v[5] = word.peer_used_5;
  assign peer_v[6] = word.peer_used_6;
  assign peer_v[7] = word.peer_used_7;

  rcam_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tx_limit  (max_tx_v),
    .num_nodes (num_nodes_v)
  );

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    rcam_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .tx_limit  (max_tx_v),
      .num_nodes (num_nodes_v),
      .peer_used (peer_v[g]),
      .cmd       (cmd[g]),
      .stat      (stat[g])
    );
  end

  rcam_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .opcode  (word.opcode),
    .channel (word.channel),
    .stat    (stat),
    .cmd     (cmd),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

endmodule
